// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL of the bounded set block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/bsmgr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsmgr_pkg
// Shared constants, state type and control/status bundles of the bounded
// set min-gap and range block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmgr_pkg;

  localparam int DATA_W          = 32;
  localparam int CAP_W           = 7;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int OUT_TDATA_W     = 72;
  localparam int OUT_TUSER_W     = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // capture the offered value and the full decision
    logic scan_rd;  // read the next stored entry
    logic commit;   // update state and load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;     // held count has reached the effective capacity
    logic empty;    // no value held
    logic last;     // scan index points at the newest held entry
    logic busy;     // distance pipeline still holds work
    logic out_free; // result register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/bounded_set_min_gap_and_range.sv -----
// ----------------------------------------------------------------------------
// bounded_set_min_gap_and_range
// Bounded store of signed numbers reporting count, smallest pairwise gap
// and value range for every offered number.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tdata[31:0] new_value
// m_axis    out  tvalid/tready    tdata: stored_count, shortest_span,
//                                  longest_span; tuser: status, spans_valid
// cfg       in   we               wdata[6:0] capacity_limit
//
// A stored number goes through an accept step, one store read per held entry,
// a drain of the read/distance pipeline and a commit step. A rejected number,
// or the first one stored, goes from accept straight to commit. A new number
// is taken only after the prior one is committed. Reset clears count, extremes
// and capacity and sets the gap to all ones; the store needs no clearing.
// The next number is taken while a result waits in the output register;
// a result stalled there holds the commit of the following number.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_min_gap_and_range #(
  parameter int MAX_ENTRIES = bsmgr_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // tdata: [31:0] new_value
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [bsmgr_pkg::DATA_W-1:0]       s_axis_tdata_i,
  // tdata: [6:0] stored_count, [38:7] shortest_span, [70:39] longest_span
  // tuser: [0] status, [1] spans_valid
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [bsmgr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  output logic [bsmgr_pkg::OUT_TUSER_W-1:0]       m_axis_tuser_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [bsmgr_pkg::CAP_W-1:0]        cfg_wdata_i
);

  bsmgr_pkg::ctrl_cmd_t  cmd;
  bsmgr_pkg::dp_status_t status;

  bsmgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsmgr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- src/bsmgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsmgr_ctrl
// Sequencer: accepts one value, sweeps the stored entries and drains the
// distance pipeline unless the store is full or empty, and commits the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsmgr_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire bsmgr_pkg::dp_status_t  status_i,
  output bsmgr_pkg::ctrl_cmd_t        cmd_o
);

  bsmgr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsmgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      bsmgr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.full || status_i.empty) begin
            state_d = bsmgr_pkg::ST_FINISH;
          end else begin
            state_d = bsmgr_pkg::ST_SCAN;
          end
        end
      end
      bsmgr_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.last) begin
          state_d = bsmgr_pkg::ST_DRAIN;
        end
      end
      bsmgr_pkg::ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = bsmgr_pkg::ST_FINISH;
        end
      end
      bsmgr_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bsmgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsmgr_pkg::ST_IDLE;
      end
    endcase
  end

  // A sweep only runs over a non-empty store
  `ASSERT_ALWAYS(a_scan_nonempty, clk_i, rst_ni,
                 (state_q != bsmgr_pkg::ST_SCAN) || !status_i.empty)

endmodule

`default_nettype wire

// ----- src/bsmgr_dp.sv -----
// ----------------------------------------------------------------------------
// bsmgr_dp
// Datapath: value store, scan index, distance pipeline, running min, max
// and gap, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsmgr_dp #(
  parameter int MAX_ENTRIES = bsmgr_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bsmgr_pkg::ctrl_cmd_t                 cmd_i,
  output bsmgr_pkg::dp_status_t                     status_o,
  input  wire logic [bsmgr_pkg::DATA_W-1:0]         in_value_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bsmgr_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [bsmgr_pkg::OUT_TDATA_W-1:0]         out_data_o,
  output logic [bsmgr_pkg::OUT_TUSER_W-1:0]         out_user_o
);

  localparam int DW  = bsmgr_pkg::DATA_W;
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = (NW > bsmgr_pkg::CAP_W) ? NW : bsmgr_pkg::CAP_W;
  localparam int PAD = bsmgr_pkg::OUT_TDATA_W - bsmgr_pkg::CAP_W - 2 * DW;

  logic [DW-1:0]              mem [MAX_ENTRIES];
  logic [bsmgr_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]              count_q;
  logic [AW-1:0]              idx_q;
  logic signed [DW-1:0]       x_q;
  logic                       reject_q;
  logic signed [DW-1:0]       min_q, max_q;
  logic [DW-1:0]              gap_q;
  logic [DW-1:0]              rd_data_q;
  logic                       rd_vld_q;
  logic [DW-1:0]              dist_q;
  logic                       dist_vld_q;
  logic                       out_valid_q;
  logic [bsmgr_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [bsmgr_pkg::OUT_TUSER_W-1:0] out_user_q;

  logic [CW-1:0]              cap_ext, cap_eff;
  logic signed [DW:0]         diff;
  logic [DW:0]                diff_abs;
  logic [CW-1:0]              count_n;
  logic signed [DW-1:0]       min_n, max_n;
  logic [DW:0]                range_n;
  logic                       spans_n;

  // Effective capacity saturates at the store depth
  assign cap_ext = CW'(cap_q);
  assign cap_eff = (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;

  assign status_o.full     = (count_q >= cap_eff);
  assign status_o.empty    = (count_q == '0);
  assign status_o.last     = (idx_q == AW'(count_q - CW'(1)));
  assign status_o.busy     = rd_vld_q || dist_vld_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Capture the offered value
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q      <= in_value_i;
      reject_q <= status_o.full;
    end
  end

  // Store: write on commit of a non-rejected number, registered read during the sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !reject_q) begin
      mem[count_q[AW-1:0]] <= x_q;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem[idx_q];
    end
  end

  // Scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.scan_rd && !status_o.last) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // Distance stage: absolute difference at 33 bits
  assign diff     = $signed({x_q[DW-1], x_q}) - $signed({rd_data_q[DW-1], rd_data_q});
  assign diff_abs = diff[DW] ? (~diff + (DW+1)'(1)) : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.scan_rd;
      dist_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      dist_q <= diff_abs[DW-1:0];
    end
  end

  // Commit values; a rejected number leaves the extremes alone
  assign count_n = count_q + CW'(!reject_q);
  assign min_n   = (!reject_q && (status_o.empty || (x_q < min_q))) ? x_q : min_q;
  assign max_n   = (!reject_q && (status_o.empty || (x_q > max_q))) ? x_q : max_q;
  assign range_n = $signed({max_n[DW-1], max_n}) - $signed({min_n[DW-1], min_n});
  assign spans_n = (count_n >= CW'(2));

  // Running state: count, extremes and smallest gap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      gap_q   <= '1;
    end else begin
      if (dist_vld_q && (dist_q < gap_q)) begin
        gap_q <= dist_q;
      end
      if (cmd_i.commit && !reject_q) begin
        count_q <= count_n;
        min_q   <= min_n;
        max_q   <= max_n;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {{PAD{1'b0}},
                     spans_n ? range_n[DW-1:0] : {DW{1'b0}},
                     spans_n ? gap_q : {DW{1'b0}},
                     count_n[bsmgr_pkg::CAP_W-1:0]};
      out_user_q <= {spans_n, reject_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Count never passes the store depth
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_ENTRIES))
  // A stored item grows the count by exactly one
  `ASSERT_NEXT(a_count_step, clk_i, rst_ni, cmd_i.commit && !reject_q,
               count_q == $past(count_q) + CW'(1))
  // Smallest gap never grows
  `ASSERT_NEXT(a_gap_mono, clk_i, rst_ni, 1'b1, gap_q <= $past(gap_q))
  // Extremes stay ordered once a value is held
  `ASSERT_ALWAYS(a_min_le_max, clk_i, rst_ni, (count_q == '0) || (min_q <= max_q))

endmodule

`default_nettype wire
